@@ src/whc_pkg.sv @@
// ----------------------------------------------------------------------------
// whc_pkg - shared types and constants of the waypoint heading controller
// Angle constants, CORDIC arctangent table, command and register codes.
// ----------------------------------------------------------------------------
package whc_pkg;

  // command codes carried in s_tuser
  localparam logic [1:0] CMD_POSE   = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_APPEND = 2'd2;

  // register indexes
  localparam logic [2:0] REG_OFFSET = 3'd0;
  localparam logic [2:0] REG_GAIN   = 3'd1;
  localparam logic [2:0] REG_SPEED  = 3'd2;
  localparam logic [2:0] REG_THRESH = 3'd3;
  localparam logic [2:0] REG_RADIUS = 3'd4;

  // angles, Q3.12 and Q.24
  localparam int PI_Q12      = 12868;
  localparam int HALF_PI_Q12 = 6434;
  localparam int TWO_PI_Q12  = 25736;
  localparam int HALF_PI_Q24 = 26353589;
  localparam int CORDIC_K    = 10188014;

  // datapath widths
  localparam int XW = 35;  // CORDIC x/y
  localparam int ZW = 29;  // CORDIC angle, Q.24

  // request into the shared CORDIC unit
  typedef struct packed {
    logic start;
    logic vec;   // 1: vectoring (atan2), 0: rotation (sine)
  } cord_req_t;

  // arctangent of 2^-i, Q.24
  function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 29'sd13176795;
      5'd1:  v = 29'sd7778716;
      5'd2:  v = 29'sd4110060;
      5'd3:  v = 29'sd2086331;
      5'd4:  v = 29'sd1047214;
      5'd5:  v = 29'sd524117;
      5'd6:  v = 29'sd262123;
      5'd7:  v = 29'sd131069;
      5'd8:  v = 29'sd65536;
      5'd9:  v = 29'sd32768;
      5'd10: v = 29'sd16384;
      5'd11: v = 29'sd8192;
      5'd12: v = 29'sd4096;
      5'd13: v = 29'sd2048;
      5'd14: v = 29'sd1024;
      5'd15: v = 29'sd512;
      5'd16: v = 29'sd256;
      5'd17: v = 29'sd128;
      5'd18: v = 29'sd64;
      5'd19: v = 29'sd32;
      5'd20: v = 29'sd16;
      5'd21: v = 29'sd8;
      5'd22: v = 29'sd4;
      5'd23: v = 29'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ src/waypoint_heading_controller_unit.sv @@
// ----------------------------------------------------------------------------
// waypoint_heading_controller_unit - go-to-goal steering controller
// Goal table, multiply sequencer and CORDIC sequencing for pose samples.
// ----------------------------------------------------------------------------
// Goal load commands (s_tuser 1 clear+add, 2 append) give no output. A pose
// sample gives one output item after it is taken, by way of the products, the
// yaw and bearing atan2, a two-pi reduction and a sine, with a second reduction
// and sine when the heading error calls for turning. The single shared CORDIC
// unit runs the yaw and bearing atan2 and one or two sines in turn, and one 17x17
// multiplier is used seven times. Past the last goal a pose sample answers at
// once with finished set. The input side is held off while a pose sample is in
// work or a result waits.
module waypoint_heading_controller_unit #(
  parameter int MAX_GOALS    = 64,
  parameter int CORDIC_STEPS = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w, goal_x, goal_y
  input  logic [127:0] s_tdata,
  // cmd
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // linear_speed, angular_speed, target_index, aligned, finished
  output logic [39:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [14:0]  cfg_data
);
  import whc_pkg::*;

  localparam int CW = $clog2(MAX_GOALS + 1);
  localparam int AW = (MAX_GOALS > 1) ? $clog2(MAX_GOALS) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_YAW  = 6'b000100,
    S_BRG  = 6'b001000,
    S_RED  = 6'b010000,
    S_SIN  = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic signed [14:0] angle_offset;
  logic [12:0] heading_gain, turn_threshold;
  logic [14:0] forward_speed, arrive_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_offset   <= -15'sd6369;
      heading_gain   <= 13'd1638;
      forward_speed  <= 15'd164;
      turn_threshold <= 13'd410;
      arrive_radius  <= 15'd410;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OFFSET: angle_offset   <= cfg_data;
        REG_GAIN:   heading_gain   <= cfg_data[12:0];
        REG_SPEED:  forward_speed  <= cfg_data;
        REG_THRESH: turn_threshold <= cfg_data[12:0];
        REG_RADIUS: arrive_radius  <= cfg_data;
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  // input fields
  logic signed [15:0] in_px, in_py, in_gx, in_gy;
  assign in_px = s_tdata[15:0];
  assign in_py = s_tdata[31:16];
  assign in_gx = s_tdata[111:96];
  assign in_gy = s_tdata[127:112];

  logic accept;
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign accept   = s_tvalid && s_tready;

  logic [CW-1:0] goal_count, goal_index;
  logic          done_latch;

  // goal table
  logic [31:0]   goal_table [MAX_GOALS];
  logic [31:0]   goal_rd;
  logic          tab_we;
  logic [AW-1:0] tab_wa;

  always_comb begin
    tab_we = 1'b0;
    tab_wa = goal_count[AW-1:0];
    if (accept && s_tuser == CMD_CLEAR) begin
      tab_we = 1'b1;
      tab_wa = '0;
    end else if (accept && s_tuser == CMD_APPEND && goal_count < CW'(MAX_GOALS)) begin
      tab_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) goal_table[tab_wa] <= {in_gy, in_gx};
    goal_rd <= goal_table[goal_index[AW-1:0]];
  end

  // latched pose
  logic signed [15:0] px, py, qx, qy, qz, qw;
  logic signed [16:0] dx, dy;
  assign dx = 17'(signed'(goal_rd[15:0])) - 17'(px);
  assign dy = 17'(signed'(goal_rd[31:16])) - 17'(py);

  // shared multiplier, one product a cycle
  logic [2:0]         k;
  logic signed [16:0] ma, mb;
  logic signed [33:0] prod;
  logic signed [34:0] sxy, syz, d2, r2;

  always_comb begin
    case (k)
      3'd0: begin ma = 17'(qx); mb = 17'(qy); end
      3'd1: begin ma = 17'(qw); mb = 17'(qz); end
      3'd2: begin ma = 17'(qy); mb = 17'(qy); end
      3'd3: begin ma = 17'(qz); mb = 17'(qz); end
      3'd4: begin ma = dx;      mb = dx;      end
      3'd5: begin ma = dy;      mb = dy;      end
      3'd6: begin ma = {2'b00, arrive_radius}; mb = {2'b00, arrive_radius}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // CORDIC
  cord_req_t            creq;
  logic signed [XW-1:0] cx0, cy0, c_y;
  logic signed [ZW-1:0] cz0, c_z;
  logic                 c_done;

  whc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .req(creq), .x0(cx0), .y0(cy0), .z0(cz0),
    .done(c_done), .y_out(c_y), .z_out(c_z)
  );

  logic signed [18:0] yaw, err, r;
  logic               sin_pass;

  // angle and sine rounding
  logic signed [ZW-1:0] z_rnd;
  logic signed [16:0]   atan_q12;
  logic signed [XW-1:0] y_rnd;
  logic signed [22:0]   s_full;
  logic signed [13:0]   s_sat;
  assign z_rnd    = c_z + ZW'(2048);
  assign atan_q12 = 17'(z_rnd >>> 12);
  assign y_rnd    = c_y + XW'(2048);
  assign s_full   = 23'(y_rnd >>> 12);
  assign s_sat    = (s_full > 23'sd4096)  ? 14'sd4096 :
                    (s_full < -23'sd4096) ? -14'sd4096 : 14'(s_full);

  // fold of a reduced angle into [-pi/2, pi/2]
  logic signed [18:0] rr, fold;
  assign rr   = (r > 19'sd12868) ? r - 19'(TWO_PI_Q12) : r;
  assign fold = (rr > 19'(HALF_PI_Q12))  ? 19'(PI_Q12) - rr :
                (rr < -19'(HALF_PI_Q12)) ? -19'(PI_Q12) - rr : rr;

  logic signed [18:0] brg_err;
  assign brg_err = 19'(atan_q12) - yaw;

  always_comb begin
    creq = '0;
    cx0  = '0;
    cy0  = '0;
    cz0  = '0;
    case (state)
      S_MUL: if (k == 3'd7) begin
        creq = '{start: 1'b1, vec: 1'b1};
        cy0  = XW'(sxy) <<< 1;
        cx0  = XW'(35'sd268435456) - (XW'(syz) <<< 1);
      end
      S_YAW: if (c_done) begin
        creq = '{start: 1'b1, vec: 1'b1};
        cy0  = XW'(dy);
        cx0  = XW'(dx);
      end
      S_RED: if (!r[18] && r < 19'(TWO_PI_Q12)) begin
        creq = '{start: 1'b1, vec: 1'b0};
        cx0  = XW'(CORDIC_K);
        cz0  = ZW'(fold) <<< 12;
      end
      default: ;
    endcase
  end

  // gain times sine; never leaves 16 bits for a 13-bit gain
  logic signed [27:0] gprod;
  logic signed [27:0] gsum;
  assign gprod = 28'(signed'({1'b0, heading_gain})) * 28'(s_sat);
  assign gsum  = gprod + 28'sd2048;

  // output register
  logic [14:0] o_lin;
  logic [15:0] o_ang;
  logic        o_aligned, o_fin;
  assign m_tdata = {o_fin, o_aligned, 7'(goal_index), o_ang, o_lin};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      goal_count <= '0;
      goal_index <= '0;
      done_latch <= 1'b0;
      k          <= '0;
      sin_pass   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (accept) begin
          case (s_tuser)
            CMD_CLEAR: begin
              goal_count <= CW'(1);
              goal_index <= '0;
              done_latch <= 1'b0;
            end
            CMD_APPEND:
              if (goal_count < CW'(MAX_GOALS)) goal_count <= goal_count + 1'b1;
            CMD_POSE:
              if (done_latch || goal_index >= goal_count) begin
                done_latch <= 1'b1;
                o_lin      <= '0;
                o_ang      <= '0;
                o_aligned  <= 1'b0;
                o_fin      <= 1'b1;
                m_tvalid   <= 1'b1;
              end else begin
                px <= in_px;  py <= in_py;
                qx <= s_tdata[47:32];  qy <= s_tdata[63:48];
                qz <= s_tdata[79:64];  qw <= s_tdata[95:80];
                k     <= '0;
                state <= S_MUL;
              end
            default: ;
          endcase
        end
        // products are registered and come out in the cycle after their operands
        S_MUL: begin
          prod <= ma * mb;
          k    <= k + 1'b1;
          case (k)
            3'd1: sxy <= 35'(prod);
            3'd2: sxy <= sxy + 35'(prod);
            3'd3: syz <= 35'(prod);
            3'd4: syz <= syz + 35'(prod);
            3'd5: d2  <= 35'(prod);
            3'd6: d2  <= d2 + 35'(prod);
            3'd7: begin
              r2    <= 35'(prod);
              state <= S_YAW;
            end
            default: ;
          endcase
        end
        S_YAW: if (c_done) begin
          yaw   <= 19'(atan_q12) + 19'(angle_offset);
          state <= S_BRG;
        end
        S_BRG: if (c_done) begin
          err      <= brg_err;
          r        <= brg_err[18] ? -brg_err : brg_err;
          sin_pass <= 1'b0;
          state    <= S_RED;
        end
        // modulo two pi by add or subtract steps
        S_RED: begin
          if (r[18])                         r <= r + 19'(TWO_PI_Q12);
          else if (r >= 19'(TWO_PI_Q12))     r <= r - 19'(TWO_PI_Q12);
          else                               state <= S_SIN;
        end
        S_SIN: if (c_done) begin
          if (!sin_pass) begin
            if (s_sat > 14'(signed'({1'b0, turn_threshold}))) begin
              sin_pass <= 1'b1;
              r        <= err;
              state    <= S_RED;
            end else begin
              o_aligned <= 1'b1;
              o_fin     <= 1'b0;
              o_ang     <= '0;
              if (d2 > r2) begin
                o_lin <= forward_speed;
              end else begin
                o_lin      <= '0;
                goal_index <= goal_index + 1'b1;
              end
              m_tvalid <= 1'b1;
              state    <= S_IDLE;
            end
          end else begin
            o_aligned <= 1'b0;
            o_fin     <= 1'b0;
            o_lin     <= '0;
            o_ang     <= 16'(gsum >>> 12);
            m_tvalid  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/whc_cordic.sv @@
// ----------------------------------------------------------------------------
// whc_cordic - shared iterative CORDIC
// One micro-rotation per cycle; vectoring mode gives atan2, rotation gives sine.
// ----------------------------------------------------------------------------
module whc_cordic #(
  parameter int STEPS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  whc_pkg::cord_req_t            req,
  input  logic signed [whc_pkg::XW-1:0] x0,
  input  logic signed [whc_pkg::XW-1:0] y0,
  input  logic signed [whc_pkg::ZW-1:0] z0,
  output logic                          done,
  output logic signed [whc_pkg::XW-1:0] y_out,
  output logic signed [whc_pkg::ZW-1:0] z_out
);
  import whc_pkg::*;

  localparam int IW = $clog2(STEPS);

  logic signed [XW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic [IW-1:0]        i;
  logic                 running, vec;
  logic                 up;
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] at;

  assign xs = x >>> i;
  assign ys = y >>> i;
  assign at = atan_q24(5'(i));
  // direction of the next micro-rotation
  assign up = vec ? y[XW-1] : !z[ZW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        vec <= req.vec;
        i   <= '0;
        z   <= z0;
        running <= 1'b1;
        if (req.vec) begin
          if (x0 == '0 && y0 == '0) begin
            // both operands zero: angle 0
            z       <= '0;
            running <= 1'b0;
            done    <= 1'b1;
          end else if (x0[XW-1] && !y0[XW-1]) begin
            x <= y0;  y <= -x0;  z <= ZW'(HALF_PI_Q24);
          end else if (x0[XW-1]) begin
            x <= -y0; y <= x0;   z <= -ZW'(HALF_PI_Q24);
          end else begin
            x <= x0;  y <= y0;   z <= '0;
          end
        end else begin
          x <= x0;
          y <= y0;
        end
      end else if (running) begin
        if (up) begin
          x <= x - ys;  y <= y + xs;  z <= z - at;
        end else begin
          x <= x + ys;  y <= y - xs;  z <= z + at;
        end
        i <= i + 1'b1;
        if (i == IW'(STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign y_out = y;
  assign z_out = z;

endmodule

@@ src/whc_checker.sv @@
// ----------------------------------------------------------------------------
// whc_checker - port-level checks of the waypoint heading controller
// Output hold, quiet commands when finished or turning, input held off.
// ----------------------------------------------------------------------------
module whc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // a waiting output item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item changed while stalled");

  // finished means both speeds zero
  a_fin: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[39] |-> m_tdata[30:0] == 31'd0)
    else $error("non-zero command after finish");

  // turning in place means no forward speed
  a_turn: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[38] |-> m_tdata[14:0] == 15'd0)
    else $error("forward speed while not aligned");

  // no new item while a result waits
  a_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while output pending");

endmodule

bind waypoint_heading_controller_unit whc_checker u_whc_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata)
);
